/* sv/bfta_pkg.sv */
package bfta_pkg;

  // Heap geometry. BLOCK_BYTES must be a power of two.
  localparam int MAX_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 4096;

  localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int NEED_W    = 33 - BLK_SHIFT;
  localparam int BIU_W     = 11;
  localparam int FLAG_W    = 3;

  // Register indexes of the configuration port.
  localparam int          CFG_IDX_W  = 1;
  localparam logic [0:0]  REG_BASE   = 1'b0;
  localparam logic [0:0]  REG_BLOCKS = 1'b1;
  localparam logic [BIU_W-1:0] BLOCKS_RESET = BIU_W'(1024);

  // Opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SIZE = 2'd2;

  // Table entry flag bits.
  localparam int FLAG_TAKEN_BIT = 0;
  localparam int FLAG_FIRST_BIT = 1;
  localparam int FLAG_NEXT_BIT  = 2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_bytes;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_FREE_IDX,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic {
    WR_CLEAR,
    WR_MARK
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_ALLOC_OK,
    RES_NO_SPACE,
    RES_ZERO_SIZE,
    RES_FREE
  } res_kind_t;

  typedef struct packed {
    logic      item_load;
    logic      idx_clr;
    logic      idx_inc;
    logic      idx_load;
    logic      scan_eval;
    logic      cnt_clr;
    logic      mark_step;
    logic      wr_en;
    wr_sel_t   wr_sel;
    rd_sel_t   rd_sel;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic too_big;
    logic free_in_range;
    logic found;
    logic idx_at_end;
    logic clear_last;
    logic mark_last;
    logic next_link;
    logic out_free;
  } sts_t;

endpackage

/* sv/bfta_ram.sv */
module bfta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/bfta_datapath.sv */
module bfta_datapath
  import bfta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output out_item_t            out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  in_item_t          item_r;
  logic [31:0]       base_r;
  logic [BIU_W-1:0]  blocks_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  out_item_t         res_r;
  logic              out_valid_r;

  logic [CNT_W-1:0]  total;
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  need_lo;
  logic [31:0]       free_off;
  logic [31:0]       free_idx;
  logic [IDX_W-1:0]  mark_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [FLAG_W-1:0] wr_data;
  logic [FLAG_W-1:0] rd_data;
  logic [FLAG_W-1:0] mark_entry;
  logic [CNT_W-1:0]  idx_plus1;

  // Effective table size, clamped to the physical table.
  assign total = (32'(blocks_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_r);

  // Block count, rounded up, in a width that cannot overflow.
  assign need    = NEED_W'(item_r.request_bytes >> BLK_SHIFT)
                 + NEED_W'(|item_r.request_bytes[BLK_SHIFT-1:0]);
  assign need_lo = need[CNT_W-1:0];

  assign free_off = item_r.free_address - base_r;
  assign free_idx = free_off >> BLK_SHIFT;

  assign idx_plus1 = CNT_W'(idx_r) + CNT_W'(1);
  assign mark_addr = start_r + k_r[IDX_W-1:0];

  always_comb begin
    mark_entry                 = '0;
    mark_entry[FLAG_TAKEN_BIT] = 1'b1;
    mark_entry[FLAG_FIRST_BIT] = (k_r == '0);
    mark_entry[FLAG_NEXT_BIT]  = ((k_r + CNT_W'(1)) < need_lo);
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO:     rd_addr = '0;
      RD_FREE_IDX: rd_addr = free_idx[IDX_W-1:0];
      RD_NEXT:     rd_addr = idx_plus1[IDX_W-1:0];
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_CLEAR: begin
        wr_addr = idx_r;
        wr_data = '0;
      end
      WR_MARK: begin
        wr_addr = mark_addr;
        wr_data = mark_entry;
      end
      default: begin
        wr_addr = idx_r;
        wr_data = '0;
      end
    endcase
  end

  bfta_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (MAX_BLOCKS)
  ) u_flags (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_load) begin
      idx_nxt = free_idx[IDX_W-1:0];
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_plus1[IDX_W-1:0];
    end
  end

  // First-fit run tracking: a taken block restarts the run.
  always_comb begin
    count_nxt = count_r;
    start_nxt = start_r;
    k_nxt     = k_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
      k_nxt     = '0;
    end else begin
      if (cmd.scan_eval) begin
        if (rd_data[FLAG_TAKEN_BIT]) begin
          count_nxt = '0;
        end else begin
          if (count_r == '0) begin
            start_nxt = idx_r;
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      if (cmd.mark_step) begin
        k_nxt = k_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      blocks_r    <= BLOCKS_RESET;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == REG_BASE)) begin
        base_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_BLOCKS)) begin
        blocks_r <= cfg_data[BIU_W-1:0];
      end
      idx_r <= idx_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    start_r <= start_nxt;
    k_r     <= k_nxt;
    if (cmd.item_load) begin
      item_r <= in_data;
    end
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_ALLOC_OK: begin
          res_r.address <= base_r + (32'(start_r) << BLK_SHIFT);
          res_r.status  <= STATUS_OK;
        end
        RES_NO_SPACE: begin
          res_r.address <= '0;
          res_r.status  <= STATUS_NO_SPACE;
        end
        RES_ZERO_SIZE: begin
          res_r.address <= '0;
          res_r.status  <= STATUS_ZERO_SIZE;
        end
        default: begin
          res_r.address <= '0;
          res_r.status  <= STATUS_OK;
        end
      endcase
    end
  end

  assign out_data  = res_r;
  assign out_valid = out_valid_r;

  always_comb begin
    sts               = '0;
    sts.is_free       = (item_r.opcode == OP_FREE);
    sts.zero_req      = (item_r.request_bytes == '0);
    sts.too_big       = (32'(need) > 32'(total));
    sts.free_in_range = (free_idx < 32'(total));
    sts.found         = !rd_data[FLAG_TAKEN_BIT] && ((count_r + CNT_W'(1)) == need_lo);
    sts.idx_at_end    = (idx_plus1 == total);
    sts.clear_last    = (idx_r == IDX_W'(MAX_BLOCKS - 1));
    sts.mark_last     = ((k_r + CNT_W'(1)) == need_lo);
    sts.next_link     = rd_data[FLAG_NEXT_BIT];
    sts.out_free      = !out_valid_r || out_ready;
  end

`ifndef SYNTHESIS
  // A run is only ever marked inside the covered part of the table.
  a_mark_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && (cmd.wr_sel == WR_MARK)) |-> (CNT_W'(mark_addr) < total))
    else $error("run marked beyond the table end");

  // A loaded result is presented in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

/* sv/bfta_ctrl.sv */
module bfta_ctrl
  import bfta_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t    state_r, state_nxt;
  res_kind_t res_kind_r, res_kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r <= res_kind_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    res_kind_nxt = res_kind_r;
    cmd          = '0;
    cmd.rd_sel   = RD_NEXT;
    cmd.wr_sel   = WR_CLEAR;
    cmd.res_kind = res_kind_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.wr_en = 1'b1;
        if (sts.clear_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_free) begin
          if (sts.free_in_range) begin
            cmd.idx_load = 1'b1;
            cmd.rd_sel   = RD_FREE_IDX;
            state_nxt    = ST_FREE;
          end else begin
            res_kind_nxt = RES_FREE;
            state_nxt    = ST_RESP;
          end
        end else if (sts.zero_req) begin
          res_kind_nxt = RES_ZERO_SIZE;
          state_nxt    = ST_RESP;
        end else if (sts.too_big) begin
          res_kind_nxt = RES_NO_SPACE;
          state_nxt    = ST_RESP;
        end else begin
          cmd.idx_clr = 1'b1;
          cmd.cnt_clr = 1'b1;
          cmd.rd_sel  = RD_ZERO;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_eval = 1'b1;
        if (sts.found) begin
          state_nxt = ST_MARK;
        end else if (sts.idx_at_end) begin
          res_kind_nxt = RES_NO_SPACE;
          state_nxt    = ST_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_MARK: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WR_MARK;
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          res_kind_nxt = RES_ALLOC_OK;
          state_nxt    = ST_RESP;
        end
      end
      ST_FREE: begin
        cmd.wr_en = 1'b1;
        if (sts.next_link && !sts.idx_at_end) begin
          cmd.idx_inc = 1'b1;
        end else begin
          res_kind_nxt = RES_FREE;
          state_nxt    = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The table is never written while waiting for a transaction.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cmd.wr_en)
    else $error("table written while idle");

  // An accepted transaction is decoded in the following cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted transaction not decoded");
`endif

endmodule

/* sv/block_table_first_fit_allocator.sv */
// First-fit allocator over a block-granular heap, tracked by a flag table.
// Input channel (in_valid/in_ready/in_data): each transaction is an allocate
// (request_bytes, rounded up to whole blocks) or a free (free_address).
// Result channel (out_valid/out_ready/out_data): exactly one transaction per
// input, with a status code and, for a placed run, its base address.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register 0
// is the heap base address, register 1 the number of table entries in use.
// Writes are always accepted and should only be made while the block is idle.
// One input transaction is processed at a time, one flag entry per cycle
// through the flag memory. An allocate that finds its run scans the entries
// up to the end of the first fitting run and then marks the run's entries;
// one that finds no run scans every entry in use. A free walks and clears
// the chain of the freed run's blocks, and a zero-size, oversized or
// out-of-heap request goes straight to the result. The result is presented
// when the block returns to idle, where it can take the next input.
// After reset the flag table is cleared one entry per cycle, all MAX_BLOCKS
// (1024) entries; no input is accepted until this is done.
// The result sits in an output register; when the receiver stalls, the next
// input is still accepted and processed, and the one after it is held off.
module block_table_first_fit_allocator
  import bfta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  // The controller sequences the clearing pass, the scan, the marking and
  // the free walk; the datapath holds the table, counters and registers.
  bfta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfta_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
